// ----- src/assert_macros.svh -----
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define WCSM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, off while reset is high
`define WCSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- src/wcsm_pkg.sv -----
`timescale 1ns / 1ps
package wcsm_pkg;

   // store geometry
   localparam int VECTOR_DEPTH = 64;
   localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

   // field widths
   localparam int LENGTH_W = 7;
   localparam int INDEX_W  = 6;
   localparam int VALUE_W  = 32;
   localparam int SUM_W    = 48;
   localparam int POINT_W  = 20;
   localparam int ENTRY_W  = 2 * VALUE_W;

   localparam logic [SUM_W-1:0]    SUM_CEILING  = '1;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(VECTOR_DEPTH);

   // command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_THEORY = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;

   typedef struct packed {
      logic [1:0]                command;
      logic [INDEX_W-1:0]        element_index;
      logic signed [VALUE_W-1:0] data_value;
      logic [VALUE_W-1:0]        inverse_variance;
      logic signed [VALUE_W-1:0] theory_value;
   } req_item_type;

   typedef struct packed {
      logic [SUM_W-1:0]   chi_square;
      logic [POINT_W-1:0] grid_point;
      logic               is_new_best;
      logic [SUM_W-1:0]   best_chi_square;
      logic [POINT_W-1:0] best_grid_point;
   } rsp_item_type;

   // request into the term pipeline
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] data;
      logic [VALUE_W-1:0]        weight;
      logic signed [VALUE_W-1:0] theory;
   } term_req_type;

   // weighted term out of the pipeline
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] term;
   } term_rsp_type;

endpackage

// ----- src/wcsm_ram.sv -----
`timescale 1ns / 1ps
module wcsm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wcsm_term.sv -----
`timescale 1ns / 1ps
module wcsm_term (
   input  logic                  clock,
   input  logic                  reset,
   input  wcsm_pkg::term_req_type term_req,
   output wcsm_pkg::term_rsp_type term_rsp
);

   logic [3:0] valid_ff;

   logic [wcsm_pkg::VALUE_W-1:0]     mag_ff;
   logic [wcsm_pkg::VALUE_W-1:0]     weight1_ff;
   logic [2*wcsm_pkg::VALUE_W-1:0]   square_ff;
   logic [wcsm_pkg::VALUE_W-1:0]     weight2_ff;
   logic [2*wcsm_pkg::VALUE_W-1:0]   prod_hi_ff;
   logic [2*wcsm_pkg::VALUE_W-1:0]   prod_lo_ff;
   logic [wcsm_pkg::SUM_W-1:0]       term_ff;

   logic signed [wcsm_pkg::VALUE_W:0] diff;
   logic [wcsm_pkg::VALUE_W:0]        mag_wide;
   logic [2*wcsm_pkg::VALUE_W:0]      term_wide;

   // exact difference and its magnitude
   always_comb begin
      diff     = {term_req.data[wcsm_pkg::VALUE_W-1], term_req.data}
               - {term_req.theory[wcsm_pkg::VALUE_W-1], term_req.theory};
      mag_wide = diff[wcsm_pkg::VALUE_W] ? (~diff + 1'b1) : diff;
   end

   // floor(square * weight / 2^32) from the two partial products
   always_comb begin
      term_wide = {1'b0, prod_hi_ff}
                + (2*wcsm_pkg::VALUE_W+1)'(prod_lo_ff[2*wcsm_pkg::VALUE_W-1:wcsm_pkg::VALUE_W]);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], term_req.valid};
      end
   end

   // datapath stages: magnitude, square, weight products, saturate
   always_ff @(posedge clock) begin
      mag_ff     <= mag_wide[wcsm_pkg::VALUE_W-1:0];
      weight1_ff <= term_req.weight;
      square_ff  <= mag_ff * mag_ff;
      weight2_ff <= weight1_ff;
      prod_hi_ff <= square_ff[2*wcsm_pkg::VALUE_W-1:wcsm_pkg::VALUE_W] * weight2_ff;
      prod_lo_ff <= square_ff[wcsm_pkg::VALUE_W-1:0] * weight2_ff;
      if (term_wide[2*wcsm_pkg::VALUE_W:wcsm_pkg::SUM_W] != '0) begin
         term_ff <= wcsm_pkg::SUM_CEILING;
      end else begin
         term_ff <= term_wide[wcsm_pkg::SUM_W-1:0];
      end
   end

   assign term_rsp.valid = valid_ff[3];
   assign term_rsp.term  = term_ff;

endmodule

// ----- src/weighted_chi_square_min_search.sv -----
// Weighted chi-square scoring with a running minimum.
// Input channel req_valid/req_ready/req_item: load a data element and its
// weight, stream one theory element, or start a new search. Result channel
// rsp_valid/rsp_ready/rsp_item: one item when a model vector completes.
// csr_we/csr_wdata write vector_length; write only while the block is idle.
// Load, start and unknown commands leave the block idle and ready for the next
// item. A theory element goes through one read of the data/weight memory, then
// four stages of the term pipeline (magnitude, square, two 32x32 weight
// products, saturate), then the add into the running sum; no new input is
// taken until that add is done. For the element that completes a vector,
// the result is shown in the same cycle that input reopens.
// A pending result does not block input; if the result register is still
// full when the next result is ready, the block holds that result and takes
// no input until rsp_ready frees the register.
// Reset clears counters, the running sum and the best (to the ceiling) and
// sets vector_length to 64; the data/weight memory is not cleared.
`timescale 1ns / 1ps
module weighted_chi_square_min_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wcsm_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wcsm_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_we,
   input  logic [wcsm_pkg::LENGTH_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_TERM,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [wcsm_pkg::LENGTH_W-1:0]     length_ff, length_in;
   logic [wcsm_pkg::LENGTH_W-1:0]     element_counter_ff, element_counter_in;
   logic [wcsm_pkg::SUM_W-1:0]        running_sum_ff, running_sum_in;
   logic [wcsm_pkg::POINT_W-1:0]      point_counter_ff, point_counter_in;
   logic [wcsm_pkg::SUM_W-1:0]        best_sum_ff, best_sum_in;
   logic [wcsm_pkg::POINT_W-1:0]      best_point_ff, best_point_in;
   logic signed [wcsm_pkg::VALUE_W-1:0] theory_ff, theory_in;
   logic                              last_ff, last_in;
   logic [wcsm_pkg::SUM_W-1:0]        final_sum_ff, final_sum_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   wcsm_pkg::rsp_item_type            rsp_item_ff, rsp_item_in;

   logic                              accept;
   logic                              mem_wr_en;
   logic                              mem_rd_en;
   logic [wcsm_pkg::ENTRY_W-1:0]      mem_rd_data;
   logic [wcsm_pkg::LENGTH_W-1:0]     eff_length;
   logic [wcsm_pkg::LENGTH_W-1:0]     count_plus;
   logic                              vector_done;
   logic [wcsm_pkg::SUM_W:0]          sum_wide;
   logic [wcsm_pkg::SUM_W-1:0]        sum_sat;
   logic                              better;
   wcsm_pkg::term_req_type            term_req;
   wcsm_pkg::term_rsp_type            term_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // data and weight memory, one entry per element
   assign mem_wr_en = accept && (req_item.command == wcsm_pkg::CMD_LOAD)
                    && (32'(req_item.element_index) < wcsm_pkg::VECTOR_DEPTH);
   assign mem_rd_en = accept && (req_item.command == wcsm_pkg::CMD_THEORY);

   wcsm_ram #(
      .DEPTH (wcsm_pkg::VECTOR_DEPTH),
      .WIDTH (wcsm_pkg::ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wcsm_pkg::ADDR_W'(req_item.element_index)),
      .wr_data ({req_item.data_value, req_item.inverse_variance}),
      .rd_en   (mem_rd_en),
      .rd_addr (element_counter_ff[wcsm_pkg::ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // term pipeline fed from the memory read
   assign term_req.valid  = (state_ff == ST_READ);
   assign term_req.data   = mem_rd_data[wcsm_pkg::ENTRY_W-1:wcsm_pkg::VALUE_W];
   assign term_req.weight = mem_rd_data[wcsm_pkg::VALUE_W-1:0];
   assign term_req.theory = theory_ff;

   wcsm_term u_term (
      .clock    (clock),
      .reset    (reset),
      .term_req (term_req),
      .term_rsp (term_rsp)
   );

   // clamp the length into 1..depth and detect the last element
   always_comb begin
      eff_length = length_ff;
      if (length_ff == '0) begin
         eff_length = wcsm_pkg::LENGTH_W'(1);
      end else if (32'(length_ff) > wcsm_pkg::VECTOR_DEPTH) begin
         eff_length = wcsm_pkg::LENGTH_W'(wcsm_pkg::VECTOR_DEPTH);
      end
      count_plus  = element_counter_ff + 1'b1;
      vector_done = (count_plus >= eff_length) || (count_plus == '0);
   end

   // saturating add of the new term and comparison against the best
   always_comb begin
      sum_wide = {1'b0, running_sum_ff} + {1'b0, term_rsp.term};
      sum_sat  = sum_wide[wcsm_pkg::SUM_W] ? wcsm_pkg::SUM_CEILING
                                           : sum_wide[wcsm_pkg::SUM_W-1:0];
      better   = final_sum_ff < best_sum_ff;
   end

   // next-state logic
   always_comb begin
      state_in           = state_ff;
      length_in          = length_ff;
      element_counter_in = element_counter_ff;
      running_sum_in     = running_sum_ff;
      point_counter_in   = point_counter_ff;
      best_sum_in        = best_sum_ff;
      best_point_in      = best_point_ff;
      theory_in          = theory_ff;
      last_in            = last_ff;
      final_sum_in       = final_sum_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_item_in        = rsp_item_ff;

      if (csr_we) begin
         length_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.command)
                  wcsm_pkg::CMD_THEORY: begin
                     theory_in          = req_item.theory_value;
                     last_in            = vector_done;
                     element_counter_in = vector_done ? '0 : count_plus;
                     state_in           = ST_READ;
                  end
                  wcsm_pkg::CMD_START: begin
                     best_sum_in        = wcsm_pkg::SUM_CEILING;
                     best_point_in      = '0;
                     running_sum_in     = '0;
                     element_counter_in = '0;
                     point_counter_in   = '0;
                  end
                  default: begin
                     // loads go straight to memory, unknown codes do nothing
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_TERM;
         end
         ST_TERM: begin
            if (term_rsp.valid) begin
               if (last_ff) begin
                  final_sum_in = sum_sat;
                  state_in     = ST_EMIT;
               end else begin
                  running_sum_in = sum_sat;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.chi_square   = final_sum_ff;
               rsp_item_in.grid_point   = point_counter_ff;
               rsp_item_in.is_new_best  = better;
               rsp_item_in.best_chi_square = better ? final_sum_ff : best_sum_ff;
               rsp_item_in.best_grid_point = better ? point_counter_ff : best_point_ff;
               if (better) begin
                  best_sum_in   = final_sum_ff;
                  best_point_in = point_counter_ff;
               end
               running_sum_in   = '0;
               point_counter_in = point_counter_ff + 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         length_ff          <= wcsm_pkg::LENGTH_RESET;
         element_counter_ff <= '0;
         running_sum_ff     <= '0;
         point_counter_ff   <= '0;
         best_sum_ff        <= wcsm_pkg::SUM_CEILING;
         best_point_ff      <= '0;
         last_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         length_ff          <= length_in;
         element_counter_ff <= element_counter_in;
         running_sum_ff     <= running_sum_in;
         point_counter_ff   <= point_counter_in;
         best_sum_ff        <= best_sum_in;
         best_point_ff      <= best_point_in;
         last_ff            <= last_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      theory_ff    <= theory_in;
      final_sum_ff <= final_sum_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- src/wcsm_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wcsm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wcsm_pkg::rsp_item_type rsp_item
);

   // a stalled result item holds
   `WCSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // the best after a model never exceeds that model's sum
   `WCSM_ASSERT_NOW(a_best_le_chi, clock, reset, rsp_valid, rsp_item.best_chi_square <= rsp_item.chi_square)

   // a new best reports this model as the best
   `WCSM_ASSERT_NOW(a_new_best, clock, reset, rsp_valid && rsp_item.is_new_best, (rsp_item.best_chi_square == rsp_item.chi_square) && (rsp_item.best_grid_point == rsp_item.grid_point))

   // no result item right after reset
   `WCSM_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind weighted_chi_square_min_search wcsm_checker u_wcsm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ----- sim/weighted_chi_square_min_search_tb.sv -----
`timescale 1ns / 1ps
module weighted_chi_square_min_search_tb;
   import wcsm_pkg::*;

   // command code the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_item_type          rsp_item;
   logic                  csr_we;
   logic [LENGTH_W-1:0]   csr_wdata;

   // run controls shared by the driver processes
   logic steady_run;
   logic ready_hold_pending;

   // scoring predictor and the queue of chi-square results still owed
   class chi_square_tracker;
      logic [VALUE_W-1:0]  data_mem [VECTOR_DEPTH];
      logic [VALUE_W-1:0]  weight_mem [VECTOR_DEPTH];
      logic [SUM_W-1:0]    run_sum;
      logic [SUM_W-1:0]    best_sum;
      logic [LENGTH_W-1:0] elem_count;
      logic [LENGTH_W-1:0] length;
      logic [POINT_W-1:0]  point_count;
      logic [POINT_W-1:0]  best_point;
      rsp_item_type        pending_scores [$];
      int unsigned         mismatches;

      function new();
         run_sum     = '0;
         best_sum    = SUM_CEILING;
         elem_count  = '0;
         length      = LENGTH_RESET;
         point_count = '0;
         best_point  = '0;
         mismatches  = 0;
         foreach (data_mem[i]) begin
            data_mem[i]   = '0;
            weight_mem[i] = '0;
         end
      endfunction

      function void set_length(logic [LENGTH_W-1:0] value);
         length = value;
      endfunction

      // weight * (data - theory)^2 in Q32.16, clipped at the ceiling
      function logic [SUM_W-1:0] scaled_square_term(logic [VALUE_W-1:0] data,
                                                    logic [VALUE_W-1:0] weight,
                                                    logic [VALUE_W-1:0] theory);
         logic signed [VALUE_W:0] diff;
         logic [VALUE_W:0]        mag;
         logic [2*VALUE_W+1:0]    square;
         logic [3*VALUE_W+1:0]    product;
         diff    = $signed({data[VALUE_W-1], data}) - $signed({theory[VALUE_W-1], theory});
         mag     = diff[VALUE_W] ? -diff : diff;
         square  = mag * mag;
         product = square * weight;
         product = product >> VALUE_W;
         if (|product[3*VALUE_W+1:SUM_W])
            return SUM_CEILING;
         return product[SUM_W-1:0];
      endfunction

      // advance the predicted state by one accepted item
      function void note_request(req_item_type item);
         logic [SUM_W:0]      total;
         logic [LENGTH_W-1:0] span;
         logic                better;
         rsp_item_type        score;
         case (item.command)
            CMD_LOAD: begin
               data_mem[item.element_index]   = item.data_value;
               weight_mem[item.element_index] = item.inverse_variance;
            end
            CMD_START: begin
               best_sum    = SUM_CEILING;
               best_point  = '0;
               run_sum     = '0;
               elem_count  = '0;
               point_count = '0;
            end
            CMD_THEORY: begin
               total = {1'b0, run_sum}
                     + {1'b0, scaled_square_term(data_mem[elem_count[ADDR_W-1:0]],
                                                 weight_mem[elem_count[ADDR_W-1:0]],
                                                 item.theory_value)};
               run_sum    = total[SUM_W] ? SUM_CEILING : total[SUM_W-1:0];
               elem_count = elem_count + 1'b1;
               // zero acts as one, anything past the store depth as the depth
               if (length == '0)
                  span = LENGTH_W'(1);
               else if (length > LENGTH_W'(VECTOR_DEPTH))
                  span = LENGTH_W'(VECTOR_DEPTH);
               else
                  span = length;
               if (elem_count >= span || elem_count == '0) begin
                  better = run_sum < best_sum;
                  if (better) begin
                     best_sum   = run_sum;
                     best_point = point_count;
                  end
                  score.chi_square      = run_sum;
                  score.grid_point      = point_count;
                  score.is_new_best     = better;
                  score.best_chi_square = best_sum;
                  score.best_grid_point = best_point;
                  pending_scores.push_back(score);
                  run_sum     = '0;
                  elem_count  = '0;
                  point_count = point_count + 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      // compare one delivered result with the oldest one owed
      function void check_result(rsp_item_type seen);
         rsp_item_type want;
         if (pending_scores.size() == 0) begin
            $error("unexpected result item: chi_square %0d grid_point %0d",
                   seen.chi_square, seen.grid_point);
            mismatches++;
            return;
         end
         want = pending_scores.pop_front();
         if (seen.chi_square !== want.chi_square) begin
            $error("chi_square expected %0d actual %0d", want.chi_square, seen.chi_square);
            mismatches++;
         end
         if (seen.grid_point !== want.grid_point) begin
            $error("grid_point expected %0d actual %0d", want.grid_point, seen.grid_point);
            mismatches++;
         end
         if (seen.is_new_best !== want.is_new_best) begin
            $error("is_new_best expected %0d actual %0d", want.is_new_best, seen.is_new_best);
            mismatches++;
         end
         if (seen.best_chi_square !== want.best_chi_square) begin
            $error("best_chi_square expected %0d actual %0d",
                   want.best_chi_square, seen.best_chi_square);
            mismatches++;
         end
         if (seen.best_grid_point !== want.best_grid_point) begin
            $error("best_grid_point expected %0d actual %0d",
                   want.best_grid_point, seen.best_grid_point);
            mismatches++;
         end
      endfunction
   endclass

   chi_square_tracker board;

   weighted_chi_square_min_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_item);
   end

   // result receiver: random stalls, plus one long hold when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (ready_hold_pending) begin
            ready_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         rsp_ready <= steady_run || ($urandom_range(0, 99) >= 14);
      end
   end

   // watchdog
   initial begin
      #2000000;
      $display("weighted_chi_square_min_search regression: fail");
      $finish;
   end

   function automatic req_item_type build_item(logic [1:0] command,
                                               logic [INDEX_W-1:0] index,
                                               logic [VALUE_W-1:0] data,
                                               logic [VALUE_W-1:0] weight,
                                               logic [VALUE_W-1:0] theory);
      req_item_type item;
      item.command          = command;
      item.element_index    = index;
      item.data_value       = data;
      item.inverse_variance = weight;
      item.theory_value     = theory;
      return item;
   endfunction

   // signed Q16.16 value: small, full range or an extreme
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] r;
      r = $urandom();
      case ($urandom_range(0, 3))
         0: return r;
         1: return {{12{r[19]}}, r[19:0]};
         2: begin
            case (r[1:0])
               2'd0: return 32'h7FFF_FFFF;
               2'd1: return 32'h8000_0000;
               2'd2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return {{16{r[15]}}, r[15:0]};
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_weight();
      logic [VALUE_W-1:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return r[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         1, 2: return r;
         default: return {14'd0, r[17:0]};
      endcase
   endfunction

   // offer one item from a falling edge, return at the falling edge after it is taken
   task automatic send_item(input req_item_type item);
      while (!steady_run && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_load(input logic [INDEX_W-1:0] index,
                            input logic [VALUE_W-1:0] data,
                            input logic [VALUE_W-1:0] weight);
      send_item(build_item(CMD_LOAD, index, data, weight, $urandom()));
   endtask

   task automatic send_theory(input logic [VALUE_W-1:0] theory);
      send_item(build_item(CMD_THEORY, INDEX_W'($urandom()), $urandom(), $urandom(), theory));
   endtask

   task automatic send_start();
      send_item(build_item(CMD_START, INDEX_W'($urandom()), $urandom(), $urandom(),
                           $urandom()));
   endtask

   task automatic send_unused();
      send_item(build_item(CMD_UNUSED, INDEX_W'($urandom()), $urandom(), $urandom(),
                           $urandom()));
   endtask

   // stop offering and let every owed result and the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_scores.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_length(input logic [LENGTH_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      board.set_length(value);
   endtask

   // stimulus
   initial begin
      int unsigned         counted;
      int unsigned         roll;
      int unsigned         phase_items;
      logic [LENGTH_W-1:0] phase_length;
      logic [VALUE_W-1:0]  r;
      logic [VALUE_W-1:0]  theory;
      board              = new();
      steady_run         = 1'b0;
      ready_hold_pending = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_item           = '0;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole store so no theory item reads an unwritten entry
      for (int i = 0; i < VECTOR_DEPTH; i++)
         send_load(INDEX_W'(i), pick_value(), pick_weight());

      // directed: saturation, exact match, ties, unknown command, restart
      write_length(LENGTH_W'(2));
      send_start();
      send_load(INDEX_W'(0), 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_load(INDEX_W'(1), 32'h0000_0000, 32'h0000_0000);
      send_theory(32'h8000_0000);
      send_theory(32'h7FFF_FFFF);
      send_load(INDEX_W'(0), 32'h1234_5678, 32'h0001_0000);
      send_load(INDEX_W'(1), 32'hFFFF_FFFF, 32'h0000_8000);
      send_theory(32'h1234_5678);
      send_theory(32'hFFFF_FFFF);
      send_theory(32'h1234_5678);
      send_theory(32'hFFFF_FFFF);
      send_theory(32'h1234_5778);
      send_theory(32'hFFFF_FFFF);
      send_unused();
      send_load(INDEX_W'(63), 32'h8000_0000, 32'hFFFF_FFFF);
      send_start();
      send_theory(32'h1234_0000);
      send_theory(32'h0000_0001);

      // length zero behaves as one, length past the depth as the depth
      write_length(LENGTH_W'(0));
      send_theory(pick_value());
      send_theory(pick_value());
      write_length(LENGTH_W'(127));
      send_theory(pick_value());
      send_theory(pick_value());
      send_theory(pick_value());
      // shrinking the length below the count so far ends the vector on the next item
      write_length(LENGTH_W'(2));
      send_theory(pick_value());

      // random phases
      counted = 0;
      for (int phase = 0; counted < 1300; phase++) begin
         case (phase)
            0: phase_length = LENGTH_W'(64);
            1: phase_length = LENGTH_W'(1);
            default: begin
               case ($urandom_range(0, 5))
                  0, 1: phase_length = LENGTH_W'($urandom_range(1, 4));
                  2:    phase_length = LENGTH_W'($urandom_range(5, 16));
                  3:    phase_length = $urandom_range(0, 1) ? LENGTH_W'(0) : LENGTH_W'(127);
                  default: phase_length = LENGTH_W'($urandom_range(1, 64));
               endcase
            end
         endcase
         write_length(phase_length);
         steady_run = (phase == 2);
         // long receiver hold so the block backs up into its input
         if (phase == 1)
            ready_hold_pending = 1'b1;
         if ($urandom_range(0, 1))
            send_start();
         phase_items = 0;
         while (phase_items < 130 && counted < 1300) begin
            roll = $urandom_range(0, 99);
            r    = $urandom();
            if (roll < 78) begin
               if ($urandom_range(0, 99) < 60)
                  theory = board.data_mem[board.elem_count[ADDR_W-1:0]]
                         + {{20{r[11]}}, r[11:0]};
               else
                  theory = pick_value();
               send_theory(theory);
            end else if (roll < 96) begin
               send_load(INDEX_W'($urandom()), pick_value(), pick_weight());
            end else if (roll < 98) begin
               send_start();
            end else begin
               send_unused();
               continue;
            end
            phase_items++;
            counted++;
         end
         steady_run = 1'b0;
      end

      // drain
      req_valid <= 1'b0;
      for (int k = 0; k < 20000 && board.pending_scores.size() != 0; k++)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (board.pending_scores.size() != 0) begin
         $error("%0d result items never arrived", board.pending_scores.size());
         board.mismatches++;
      end
      if (board.mismatches == 0)
         $display("weighted_chi_square_min_search regression: pass");
      else
         $display("weighted_chi_square_min_search regression: fail");
      $finish;
   end

endmodule
